/* src/prq_pkg.sv */
// Package for the priority ready queue: payload types, codes and sequencer states.
package prq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int ID_W   = 16;
	localparam int PRIO_W = 6;
	localparam int STAT_W = 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic REG_IDLE_ID = 1'b0;

	typedef struct packed {
		logic              opcode;
		logic [ID_W-1:0]   thread_id;
		logic [PRIO_W-1:0] priority_req;
	} req_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   chosen_id;
		logic [PRIO_W-1:0] chosen_priority;
		logic [STAT_W-1:0] status;
	} rsp_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

/* src/priority_ready_queue.sv */
// Strict priority ready queue with oldest-first tie-break, scanned by one comparator.
//
// Entries are kept in insertion order in a single-port-write, single-port-read memory of
// QUEUE_DEPTH entries. A push's result passes through the result register and then the output
// register. A pop reads the stored entries one per cycle through the registered memory port
// and compares each against the running best, then closes the gap by copying the entries
// behind the winner one place forward, one per cycle; the memory port sets the pace of a pop.
// The block takes no new item while an item is at work or waits in S_DONE. A finished
// result waits in an output register; the next item may be taken, but its result holds in
// S_DONE until that register is free.
module priority_ready_queue #(
	parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  prq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output prq_pkg::rsp_item_t rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import prq_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t mem [QUEUE_DEPTH];

	state_t state_q, state_d;

	logic [ID_W-1:0]  idle_id_q;
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [CNT_W-1:0] cmp_cnt_q;
	logic [CNT_W-1:0] sh_cnt_q;
	logic [IDX_W-1:0] best_idx_q;
	entry_t           best_q;
	entry_t           rd_data_s1;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] wr_addr_s1;
	rsp_item_t        res_q;
	rsp_item_t        rsp_q;
	logic             rsp_valid_q;

	logic             req_fire;
	logic             full;
	logic             issue;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic             better;
	logic             scan_last;
	logic             shift_done;
	logic             out_free;
	logic [IDX_W-1:0] best_idx_next;

	assign full       = (occ_q == CNT_W'(QUEUE_DEPTH));
	assign req_fire   = req_valid && req_ready;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign better     = (cmp_cnt_q == '0) || (rd_data_s1.prio > best_q.prio);
	assign scan_last  = rd_vld_s1 && (cmp_cnt_q == occ_q - CNT_W'(1));
	assign shift_done = !issue && !rd_vld_s1;
	assign best_idx_next = better ? cmp_cnt_q[IDX_W-1:0] : best_idx_q;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDLE_ID) ? {16'd0, idle_id_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_id_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDLE_ID) begin
			idle_id_q <= pwdata[ID_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.opcode == OP_POP && occ_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (shift_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake, memory read and write controls.
	always_comb begin
		req_ready = 1'b0;
		issue     = 1'b0;
		rd_addr   = rd_cnt_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = occ_q[IDX_W-1:0];
		mem_wdata = '{id: req.thread_id, prio: req.priority_req};
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				mem_we    = req_valid && req.opcode == OP_PUSH && !full;
			end
			S_SCAN: begin
				issue   = (rd_cnt_q < occ_q);
				rd_addr = rd_cnt_q[IDX_W-1:0];
			end
			S_SHIFT: begin
				issue     = (sh_cnt_q < occ_q);
				rd_addr   = sh_cnt_q[IDX_W-1:0];
				mem_we    = rd_vld_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = rd_data_s1;
			end
			S_DONE: begin
				req_ready = 1'b0;
			end
			default: req_ready = 1'b0;
		endcase
	end

	// Entry store with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[rd_addr];
		wr_addr_s1 <= rd_addr - IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (state_q == S_IDLE && req_fire && req.opcode == OP_PUSH && !full) begin
				occ_q <= occ_q + CNT_W'(1);
			end else if (state_q == S_SHIFT && shift_done) begin
				occ_q <= occ_q - CNT_W'(1);
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Scan counters, running best and result register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rd_cnt_q  <= '0;
				cmp_cnt_q <= '0;
				if (req.opcode == OP_PUSH) begin
					res_q <= '{chosen_id: '0, chosen_priority: '0,
						status: full ? ST_FULL : ST_OK};
				end else begin
					res_q <= '{chosen_id: idle_id_q, chosen_priority: '0, status: ST_EMPTY};
				end
			end
			S_SCAN: begin
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (rd_vld_s1) begin
					cmp_cnt_q <= cmp_cnt_q + CNT_W'(1);
					if (better) begin
						best_q <= rd_data_s1;
					end
					best_idx_q <= best_idx_next;
				end
				// The copy pass starts with the entry just behind the winner.
				sh_cnt_q <= {{(CNT_W-IDX_W){1'b0}}, best_idx_next} + CNT_W'(1);
			end
			S_SHIFT: begin
				if (issue) begin
					sh_cnt_q <= sh_cnt_q + CNT_W'(1);
				end
				res_q <= '{chosen_id: best_q.id, chosen_priority: best_q.prio, status: ST_OK};
			end
			S_DONE: begin
				if (out_free) begin
					rsp_q <= res_q;
				end
			end
			default: rd_cnt_q <= '0;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* dv/priority_ready_queue_test.sv */
// Self-checking testbench for the priority ready queue: random and directed items with a predictor.
`timescale 1ns / 1ps

module priority_ready_queue_test;
	import prq_pkg::*;

	localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
	localparam int PHASE_ITEMS = 350;
	localparam logic [2:0] IDLE_ID_ADDR = {REG_IDLE_ID, 2'b00};
	localparam logic [2:0] UNUSED_REG_ADDR = 3'd4;

	// Tracks the queue contents and the idle id, and holds the results still owed by the block.
	class ready_queue_tracker;
		entry_t          stored[$];
		rsp_item_t       owed_results[$];
		logic [ID_W-1:0] idle_value;
		int              depth;
		int              failures;

		function new(int depth);
			this.depth = depth;
			idle_value = '0;
			failures = 0;
		endfunction

		function void write_register(logic [2:0] addr, logic [31:0] value);
			if (addr == IDLE_ID_ADDR) begin
				idle_value = value[ID_W-1:0];
			end
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		function void note_request(req_item_t it);
			rsp_item_t pick;
			entry_t    fresh;
			int        best;
			pick = '0;
			if (it.opcode == OP_PUSH) begin
				if (stored.size() >= depth) begin
					pick.status = ST_FULL;
				end else begin
					fresh.id = it.thread_id;
					fresh.prio = it.priority_req;
					stored.push_back(fresh);
					pick.status = ST_OK;
				end
			end else if (stored.size() == 0) begin
				pick.chosen_id = idle_value;
				pick.status = ST_EMPTY;
			end else begin
				// Strictly greater keeps the oldest entry among equal priorities.
				best = 0;
				for (int i = 1; i < stored.size(); i++) begin
					if (stored[i].prio > stored[best].prio) begin
						best = i;
					end
				end
				pick.chosen_id = stored[best].id;
				pick.chosen_priority = stored[best].prio;
				pick.status = ST_OK;
				stored.delete(best);
			end
			owed_results.push_back(pick);
		endfunction

		function void mismatch(string field, logic [31:0] want, logic [31:0] got);
			failures++;
			if (failures <= 10) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			end
		endfunction

		function void check_result(rsp_item_t got);
			rsp_item_t want;
			if (owed_results.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("%0t: result %0h arrived with nothing expected", $time, got);
				end
				return;
			end
			want = owed_results.pop_front();
			if (got.chosen_id !== want.chosen_id) begin
				mismatch("chosen_id", want.chosen_id, got.chosen_id);
			end
			if (got.chosen_priority !== want.chosen_priority) begin
				mismatch("chosen_priority", want.chosen_priority, got.chosen_priority);
			end
			if (got.status !== want.status) begin
				mismatch("status", want.status, got.status);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_item_t   req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_item_t   rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          idle_cycles = 0;

	ready_queue_tracker tracker = new(QUEUE_DEPTH);

	priority_ready_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, some short ones and a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 50);
	endfunction

	function automatic req_item_t make_req(logic op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
		req_item_t it;
		it.opcode = op;
		it.thread_id = id;
		it.priority_req = prio;
		return it;
	endfunction

	// Offers one item and returns at the edge where it is taken. A gap lowers valid afterwards.
	task automatic offer_request(req_item_t it, int gap);
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		tracker.note_request(it);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every owed result has come back.
	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	task automatic write_register(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_register(addr, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_directed();
		logic [PRIO_W-1:0] ladder [16];
		ladder = '{6'd0, 6'd63, 6'd63, 6'd1, 6'd62, 6'd32, 6'd31, 6'd0,
			6'd63, 6'd5, 6'd5, 6'd17, 6'd40, 6'd63, 6'd2, 6'd1};
		// Pop on an empty queue with the idle id still at its reset value.
		offer_request(make_req(OP_POP, 16'($urandom), 6'($urandom)), pick_gap());
		settle();
		write_register(IDLE_ID_ADDR, {16'($urandom), 16'hFFFF});
		offer_request(make_req(OP_POP, 16'($urandom), 6'($urandom)), pick_gap());
		// Fill the queue, with ties on the top priority at several positions.
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			offer_request(make_req(OP_PUSH, {4{4'(i)}}, ladder[i]), pick_gap());
		end
		offer_request(make_req(OP_PUSH, 16'h5A5A, 6'd63), pick_gap());
		for (int i = 0; i < 5; i++) begin
			offer_request(make_req(OP_POP, 16'($urandom), 6'($urandom)), pick_gap());
		end
	endtask

	// Bursts lean toward pushes or pops, or mix them evenly, so the queue keeps reaching full and empty.
	task automatic run_random(int count);
		int        left;
		int        op_mode;
		int        prio_mode;
		bit        quiet;
		int        r;
		req_item_t it;
		left = 0;
		for (int n = 0; n < count; n++) begin
			if (left == 0) begin
				op_mode = $urandom_range(0, 2);
				prio_mode = $urandom_range(0, 2);
				quiet = ($urandom_range(0, 3) == 0);
				left = $urandom_range(10, 40);
			end
			left--;
			r = $urandom_range(0, 99);
			case (op_mode)
				0: it.opcode = (r < 85) ? OP_PUSH : OP_POP;
				1: it.opcode = (r < 85) ? OP_POP : OP_PUSH;
				default: it.opcode = (r < 50) ? OP_PUSH : OP_POP;
			endcase
			r = $urandom_range(0, 99);
			if (r < 8) begin
				it.thread_id = '0;
			end else if (r < 16) begin
				it.thread_id = '1;
			end else begin
				it.thread_id = 16'($urandom);
			end
			case (prio_mode)
				0: it.priority_req = 6'($urandom_range(0, 3));
				1: it.priority_req = ($urandom_range(0, 1) == 1) ? 6'd63 : 6'd0;
				default: it.priority_req = 6'($urandom);
			endcase
			offer_request(it, quiet ? 0 : pick_gap());
		end
	endtask

	initial begin : stimulus
		logic [ID_W-1:0] idle_values [4];
		idle_values = '{16'h0000, 16'($urandom), 16'hFFFF, 16'($urandom)};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < 4; p++) begin
			settle();
			write_register(UNUSED_REG_ADDR, $urandom);
			write_register(IDLE_ID_ADDR, {16'($urandom), idle_values[p]});
			run_random(PHASE_ITEMS);
		end
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("priority_ready_queue test passed");
		end else begin
			$display("priority_ready_queue test failed");
		end
		$finish;
	end

	// Result side: random stalls, quiet stretches, and two long hold-offs that back up the input.
	initial begin : result_sink
		int stall_left;
		int seen;
		stall_left = 0;
		seen = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				tracker.check_result(rsp);
				seen++;
				if (seen == 300 || seen == 1100) begin
					stall_left = HOLD_OFF_CYCLES;
				end
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				if ((seen / 200) % 2 == 0) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("priority_ready_queue test failed");
			$finish;
		end
	end

endmodule
